// ----- hdl/humidity_temp_frame_decoder_core_macros.svh -----
// assertion macros shared by the frame decoder checker
// expects signals named clk and arst_n in the scope of use
`ifndef HUMIDITY_TEMP_FRAME_DECODER_CORE_MACROS_SVH
`define HUMIDITY_TEMP_FRAME_DECODER_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define HTFD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define HTFD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/htfd_pkg.sv -----
// shared constants, byte position codes and crc-8 step for the frame decoder
// no dependencies
package htfd_pkg;

	localparam logic [7:0] CRC_POLY = 8'h31;
	localparam logic [7:0] CRC_INIT = 8'hFF;

	localparam logic [12:0] TEMP_MUL    = 13'd4375;
	localparam int          TEMP_SHIFT  = 14;
	localparam logic [14:0] TEMP_OFFSET = 15'd4500;
	localparam logic [9:0]  HUM_MUL     = 10'd625;
	localparam int          HUM_SHIFT   = 12;

	typedef logic [2:0] pos_t;

	// byte position within the six-byte frame
	localparam pos_t POS_TEMP_HI  = 3'd0;
	localparam pos_t POS_TEMP_LO  = 3'd1;
	localparam pos_t POS_TEMP_CRC = 3'd2;
	localparam pos_t POS_HUM_HI   = 3'd3;
	localparam pos_t POS_HUM_LO   = 3'd4;
	localparam pos_t POS_HUM_CRC  = 3'd5;

	// msb-first crc-8, no final xor
	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

// ----- hdl/humidity_temp_frame_decoder_core.sv -----
// channel | direction | handshake          | payload
// in      | receive   | in_valid/in_stall   | rx_byte, frame_begin
// out     | send      | out_valid/out_stall | temperature_centi, humidity_centi,
//         |           |                     | temp_check_ok, hum_check_ok, frame_valid
//
// one byte enters per cycle while in_stall is low; each byte passes through the input register
// the frame result is loaded into the output register at the edge where the sixth byte
// leaves the input register, and out_valid rises at that same edge
// the crc step and both constant multiplies sit between the input and output registers
// arst_n clears the byte position and both valid bits and sets the running crc to CRC_INIT
// a stalled result holds back only a closing byte of the next frame; bytes behind it wait
//
// top level of the humidity/temperature frame decoder; uses htfd_pkg and htfd_scale
module humidity_temp_frame_decoder_core
	import htfd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         rx_byte,
	input  logic               frame_begin,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [14:0] temperature_centi,
	output logic [13:0]        humidity_centi,
	output logic               temp_check_ok,
	output logic               hum_check_ok,
	output logic               frame_valid
);

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       begin_s1;

	// frame state
	pos_t       pos_q;
	logic [7:0] crc_q;
	logic [7:0] first_hi_q;   // temp high byte, later the humidity low byte
	logic [15:0] temp_word_q;
	logic        temp_good_q;
	logic [7:0]  hum_hi_q;

	// output register
	logic               out_valid_q;
	logic signed [14:0] temp_q;
	logic [13:0]        hum_q;
	logic               temp_ok_q;
	logic               hum_ok_q;

	pos_t               pos_eff;
	logic               has_result;
	logic               out_free;
	logic               adv_s1;
	logic               in_take;
	logic [7:0]         crc_step;
	logic               hum_ok;
	logic signed [14:0] temp_calc;
	logic [13:0]        hum_calc;

	// a frame-begin byte or an unreachable position restarts at the first byte
	assign pos_eff    = (begin_s1 || pos_q > POS_HUM_CRC) ? POS_TEMP_HI : pos_q;
	assign has_result = (pos_eff == POS_HUM_CRC);

	assign out_free = !out_valid_q || !out_stall;
	assign adv_s1   = valid_s1 && (!has_result || out_free);
	assign in_stall = valid_s1 && !adv_s1;
	assign in_take  = in_valid && !in_stall;

	// the crc restarts on the high byte of each word
	assign crc_step = crc8_byte(
		(pos_eff == POS_TEMP_HI || pos_eff == POS_HUM_HI) ? CRC_INIT : crc_q, byte_s1);
	assign hum_ok   = (byte_s1 == crc_q);

	htfd_scale u_scale (
		.temp_word         (temp_word_q),
		.hum_word          ({hum_hi_q, first_hi_q}),
		.temperature_centi (temp_calc),
		.humidity_centi    (hum_calc)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			byte_s1  <= rx_byte;
			begin_s1 <= frame_begin;
		end
	end

	// frame state moves on as each byte leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= POS_TEMP_HI;
			crc_q       <= CRC_INIT;
			first_hi_q  <= '0;
			temp_word_q <= '0;
			temp_good_q <= 1'b0;
			hum_hi_q    <= '0;
		end else if (adv_s1) begin
			unique case (pos_eff)
				POS_TEMP_HI: begin
					crc_q      <= crc_step;
					first_hi_q <= byte_s1;
					pos_q      <= POS_TEMP_LO;
				end
				POS_TEMP_LO: begin
					crc_q       <= crc_step;
					temp_word_q <= {first_hi_q, byte_s1};
					pos_q       <= POS_TEMP_CRC;
				end
				POS_TEMP_CRC: begin
					temp_good_q <= (byte_s1 == crc_q);
					crc_q       <= CRC_INIT;
					pos_q       <= POS_HUM_HI;
				end
				POS_HUM_HI: begin
					crc_q    <= crc_step;
					hum_hi_q <= byte_s1;
					pos_q    <= POS_HUM_LO;
				end
				POS_HUM_LO: begin
					crc_q      <= crc_step;
					first_hi_q <= byte_s1;
					pos_q      <= POS_HUM_CRC;
				end
				POS_HUM_CRC: begin
					crc_q <= CRC_INIT;
					pos_q <= POS_TEMP_HI;
				end
				default: begin
					pos_q <= POS_TEMP_HI;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && has_result) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && has_result) begin
			temp_q    <= temp_calc;
			hum_q     <= hum_calc;
			temp_ok_q <= temp_good_q;
			hum_ok_q  <= hum_ok;
		end
	end

	assign out_valid         = out_valid_q;
	assign temperature_centi = temp_q;
	assign humidity_centi    = hum_q;
	assign temp_check_ok     = temp_ok_q;
	assign hum_check_ok      = hum_ok_q;
	assign frame_valid       = temp_ok_q && hum_ok_q;

endmodule

// ----- hdl/htfd_scale.sv -----
// raw sensor words to hundredths of a degree and of a percent
// uses htfd_pkg for the scaling constants
module htfd_scale
	import htfd_pkg::*;
(
	input  logic [15:0]        temp_word,
	input  logic [15:0]        hum_word,
	output logic signed [14:0] temperature_centi,
	output logic [13:0]        humidity_centi
);

	logic [28:0] temp_prod;
	logic [25:0] hum_prod;
	logic [14:0] temp_scaled;

	assign temp_prod = 29'(TEMP_MUL) * 29'(temp_word);
	assign hum_prod  = 26'(HUM_MUL) * 26'(hum_word);

	// 4375 * 65535 >> 14 fits in 15 bits
	assign temp_scaled       = temp_prod[TEMP_SHIFT +: 15];
	assign temperature_centi = $signed(temp_scaled - TEMP_OFFSET);
	assign humidity_centi    = hum_prod[HUM_SHIFT +: 14];

endmodule

// ----- hdl/htfd_checker.sv -----
// port-level checks on the frame decoder, bound to the top level
// uses the assertion macros header
`include "humidity_temp_frame_decoder_core_macros.svh"

module htfd_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_stall,
	input logic signed [14:0] temperature_centi,
	input logic [13:0]        humidity_centi,
	input logic               temp_check_ok,
	input logic               hum_check_ok,
	input logic               frame_valid
);

	`HTFD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped while stalled")
	`HTFD_ASSERT_NOW(a_valid_flag, out_valid, frame_valid == (temp_check_ok && hum_check_ok), "frame_valid disagrees with crc flags")
	`HTFD_ASSERT_NOW(a_hum_range, out_valid, humidity_centi <= 14'd9999, "humidity out of range")
	`HTFD_ASSERT_NOW(a_temp_range, out_valid, temperature_centi >= -15'sd4500 && temperature_centi <= 15'sd12999, "temperature out of range")

endmodule

bind humidity_temp_frame_decoder_core htfd_checker u_htfd_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.out_valid         (out_valid),
	.out_stall         (out_stall),
	.temperature_centi (temperature_centi),
	.humidity_centi    (humidity_centi),
	.temp_check_ok     (temp_check_ok),
	.hum_check_ok      (hum_check_ok),
	.frame_valid       (frame_valid)
);

// ----- tb/humidity_temp_frame_decoder_checker.sv -----
`timescale 1ns / 100ps
// checker for the humidity/temperature frame decoder: mirrors the byte decoding,
// keeps the decoded frames still owed by the block and compares each delivered one
// depends on htfd_pkg for the byte position codes
module humidity_temp_frame_decoder_checker
	import htfd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic [7:0]         rx_byte,
	input  logic               frame_begin,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic signed [14:0] temperature_centi,
	input  logic [13:0]        humidity_centi,
	input  logic               temp_check_ok,
	input  logic               hum_check_ok,
	input  logic               frame_valid,
	output int                 failures,
	output int                 pending,
	output int                 frames_compared
);

	localparam logic [7:0] SENSOR_POLY = 8'h31;
	localparam logic [7:0] SENSOR_SEED = 8'hFF;

	typedef struct packed {
		logic signed [14:0] temp;
		logic [13:0]        hum;
		logic               temp_ok;
		logic               hum_ok;
		logic               both_ok;
	} decoded_frame_t;

	decoded_frame_t pending_frames[$];

	pos_t        byte_pos;
	logic [7:0]  crc_acc;
	logic [7:0]  held_byte;
	logic [7:0]  hum_hi;
	logic [15:0] temp_raw;
	logic        temp_crc_ok;
	int          fail_cnt;
	int          done_cnt;

	// serial form of the crc: one message bit per shift
	function automatic logic [7:0] crc_shift_in(input logic [7:0] crc, input logic [7:0] data);
		logic [7:0] r;
		logic       fb;
		r = crc;
		for (int i = 7; i >= 0; i--) begin
			fb = r[7] ^ data[i];
			r = {r[6:0], 1'b0} ^ (fb ? SENSOR_POLY : 8'h00);
		end
		return r;
	endfunction

	task automatic decode_byte(input logic [7:0] b, input logic first);
		pos_t           p;
		decoded_frame_t f;
		logic [31:0]    t_prod;
		logic [31:0]    h_prod;
		logic           h_ok;
		p = first ? POS_TEMP_HI : byte_pos;
		if (p > POS_HUM_CRC) begin
			p = POS_TEMP_HI;
		end
		case (p)
			POS_TEMP_LO: begin
				crc_acc = crc_shift_in(crc_acc, b);
				temp_raw = {held_byte, b};
				byte_pos = POS_TEMP_CRC;
			end
			POS_TEMP_CRC: begin
				temp_crc_ok = (b == crc_acc);
				crc_acc = SENSOR_SEED;
				byte_pos = POS_HUM_HI;
			end
			POS_HUM_HI: begin
				crc_acc = crc_shift_in(SENSOR_SEED, b);
				hum_hi = b;
				byte_pos = POS_HUM_LO;
			end
			POS_HUM_LO: begin
				crc_acc = crc_shift_in(crc_acc, b);
				held_byte = b;
				byte_pos = POS_HUM_CRC;
			end
			POS_HUM_CRC: begin
				h_ok = (b == crc_acc);
				t_prod = 32'd4375 * {16'd0, temp_raw};
				h_prod = 32'd625 * {16'd0, hum_hi, held_byte};
				f.temp = 15'((t_prod >> 14) - 32'd4500);
				f.hum = 14'(h_prod >> 12);
				f.temp_ok = temp_crc_ok;
				f.hum_ok = h_ok;
				f.both_ok = temp_crc_ok & h_ok;
				pending_frames.push_back(f);
				crc_acc = SENSOR_SEED;
				byte_pos = POS_TEMP_HI;
			end
			default: begin
				crc_acc = crc_shift_in(SENSOR_SEED, b);
				held_byte = b;
				byte_pos = POS_TEMP_LO;
			end
		endcase
	endtask

	task automatic check_field(input string field, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
			fail_cnt++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		decoded_frame_t f;
		if (!arst_n) begin
			byte_pos = POS_TEMP_HI;
			crc_acc = SENSOR_SEED;
			held_byte = '0;
			hum_hi = '0;
			temp_raw = '0;
			temp_crc_ok = 1'b0;
			pending_frames.delete();
			fail_cnt = 0;
			done_cnt = 0;
			failures <= 0;
			pending <= 0;
			frames_compared <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (pending_frames.size() == 0) begin
					$display("%0t: unexpected frame, actual temp %0d hum %0d flags %b%b%b",
						$time, temperature_centi, humidity_centi,
						temp_check_ok, hum_check_ok, frame_valid);
					fail_cnt++;
				end else begin
					f = pending_frames.pop_front();
					check_field("temperature_centi", f.temp, temperature_centi);
					check_field("humidity_centi", f.hum, humidity_centi);
					check_field("temp_check_ok", f.temp_ok, temp_check_ok);
					check_field("hum_check_ok", f.hum_ok, hum_check_ok);
					check_field("frame_valid", f.both_ok, frame_valid);
					done_cnt++;
				end
			end
			if (in_valid && !in_stall) begin
				decode_byte(rx_byte, frame_begin);
			end
			failures <= fail_cnt;
			pending <= pending_frames.size();
			frames_compared <= done_cnt;
		end
	end

endmodule

// ----- tb/tb_humidity_temp_frame_decoder_core.sv -----
`timescale 1ns / 100ps
// top of the frame decoder testbench: clock, reset, byte stimulus and the verdict
// depends on humidity_temp_frame_decoder_core, its package and the checker module
module tb_humidity_temp_frame_decoder_core;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [7:0]         rx_byte;
	logic               frame_begin;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic signed [14:0] temperature_centi;
	logic [13:0]        humidity_centi;
	logic               temp_check_ok;
	logic               hum_check_ok;
	logic               frame_valid;

	int failures;
	int pending;
	int frames_compared;

	// handshake pressure, percent per cycle
	int idle_pct  = 0;
	int stall_pct = 0;

	int   bytes_sent = 0;
	// set when the decoder is known to sit at byte position zero
	logic aligned = 1'b1;

	humidity_temp_frame_decoder_core u_top (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.rx_byte           (rx_byte),
		.frame_begin       (frame_begin),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.temperature_centi (temperature_centi),
		.humidity_centi    (humidity_centi),
		.temp_check_ok     (temp_check_ok),
		.hum_check_ok      (hum_check_ok),
		.frame_valid       (frame_valid)
	);

	humidity_temp_frame_decoder_checker u_chk (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.rx_byte           (rx_byte),
		.frame_begin       (frame_begin),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.temperature_centi (temperature_centi),
		.humidity_centi    (humidity_centi),
		.temp_check_ok     (temp_check_ok),
		.hum_check_ok      (hum_check_ok),
		.frame_valid       (frame_valid),
		.failures          (failures),
		.pending           (pending),
		.frames_compared   (frames_compared)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// receiver back-pressure, redrawn every cycle
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// checksum the way the sensor builds it: byte-wise xor, then eight shifts per byte
	function automatic logic [7:0] sensor_crc(input logic [15:0] w);
		logic [7:0] c;
		c = 8'hFF ^ w[15:8];
		for (int i = 0; i < 16; i++) begin
			if (i == 8) begin
				c = c ^ w[7:0];
			end
			c = c[7] ? ({c[6:0], 1'b0} ^ 8'h31) : {c[6:0], 1'b0};
		end
		return c;
	endfunction

	// raw words lean toward the range ends now and then
	function automatic logic [15:0] pick_word();
		case ($urandom_range(9))
			0:       return 16'h0000;
			1:       return 16'hFFFF;
			default: return 16'($urandom_range(16'hFFFF));
		endcase
	endfunction

	// one item: optional idle cycles, then hold the byte until it is taken
	task automatic send_byte(input logic [7:0] b, input logic first);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		frame_begin <= first;
		do @(posedge clk); while (in_stall);
		bytes_sent++;
	endtask

	// first n_bytes of a measurement frame; a bad flag spoils that word's checksum
	task automatic send_frame(input logic [15:0] t_raw, input logic [15:0] h_raw,
			input logic t_bad, input logic h_bad, input logic first, input int n_bytes);
		logic [7:0] fbytes [6];
		fbytes[0] = t_raw[15:8];
		fbytes[1] = t_raw[7:0];
		fbytes[2] = sensor_crc(t_raw) ^ (t_bad ? 8'($urandom_range(1, 255)) : 8'h00);
		fbytes[3] = h_raw[15:8];
		fbytes[4] = h_raw[7:0];
		fbytes[5] = sensor_crc(h_raw) ^ (h_bad ? 8'($urandom_range(1, 255)) : 8'h00);
		for (int i = 0; i < n_bytes; i++) begin
			send_byte(fbytes[i], (i == 0) ? first : 1'b0);
		end
	endtask

	// mostly clean frames, some cut short, some raw noise
	task automatic send_random_burst();
		int   kind;
		logic fb0;
		kind = $urandom_range(99);
		// a frame that starts at position zero may leave the begin flag low
		fb0 = aligned ? ($urandom_range(3) != 0) : 1'b1;
		if (kind < 70) begin
			send_frame(pick_word(), pick_word(), $urandom_range(99) < 15,
				$urandom_range(99) < 15, fb0, 6);
			aligned = 1'b1;
		end else if (kind < 85) begin
			send_frame(pick_word(), pick_word(), 1'($urandom_range(1)),
				1'($urandom_range(1)), fb0, $urandom_range(1, 5));
			aligned = 1'b0;
		end else begin
			repeat ($urandom_range(1, 8)) begin
				send_byte(8'($urandom_range(255)), $urandom_range(99) < 20);
			end
			aligned = 1'b0;
		end
	endtask

	// stop feeding and let the decoder drain every owed frame
	task automatic drain_frames();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	initial begin
		int phase_idle  [4];
		int phase_stall [4];
		int phase_end;
		phase_idle  = '{0, 47, 0, 37};
		phase_stall = '{0, 0, 47, 37};
		arst_n = 1'b0;
		in_valid <= 1'b0;
		rx_byte <= 8'h00;
		frame_begin <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed frames, no pressure
		// all-zero words, begin flag low straight out of reset
		send_frame(16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0, 6);
		// all-ones words: top of both output ranges
		send_frame(16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 1'b1, 6);
		// temperature checksum corrupted, values still reported
		send_frame(16'h6666, 16'h8000, 1'b1, 1'b0, 1'b1, 6);
		// frame abandoned inside the humidity word, then a restart
		send_frame(16'h1234, 16'hABCD, 1'b0, 1'b0, 1'b1, 4);
		// restarted frame with the humidity checksum corrupted
		send_frame(16'h8000, 16'h7FFF, 1'b0, 1'b1, 1'b1, 6);
		// hold off until the decoder has delivered everything so far
		drain_frames();

		// random traffic in four handshake phases, drained between phases
		for (int ph = 0; ph < 4; ph++) begin
			idle_pct = phase_idle[ph];
			stall_pct = phase_stall[ph];
			phase_end = bytes_sent + 105;
			while (bytes_sent < phase_end) begin
				send_random_burst();
			end
			drain_frames();
		end

		// leave room for any stray frame to show up
		repeat (8) @(posedge clk);
		$display("covered %0d bytes over clean, idle, stall and mixed handshake phases",
			bytes_sent);
		$display("%0d decoded frames compared field by field", frames_compared);
		if (failures == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#2000000;
		$display("Verification failed");
		$finish;
	end

endmodule

// ----- humidity_temp_frame_decoder_core.f -----
+incdir+hdl
hdl/htfd_pkg.sv
hdl/htfd_scale.sv
hdl/humidity_temp_frame_decoder_core.sv
hdl/htfd_checker.sv
tb/humidity_temp_frame_decoder_checker.sv
tb/tb_humidity_temp_frame_decoder_core.sv
